FILE: hdl/char_lcd_write_sequencer_top_assert.svh
// ----------------------------------------------------------------------------
// char_lcd_write_sequencer_top_assert.svh
// assertion macros used by the lcd sequencer checker
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_WRITE_SEQUENCER_TOP_ASSERT_SVH
`define CHAR_LCD_WRITE_SEQUENCER_TOP_ASSERT_SVH

// same-cycle implication
`define CLCD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CLCD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/clcd_pkg.sv
// ----------------------------------------------------------------------------
// clcd_pkg
// shared types and constants of the character lcd write sequencer
// ----------------------------------------------------------------------------
`default_nettype none

package clcd_pkg;

    localparam int TICK_COUNT_BITS_DEF = 16;
    localparam int PHASE_TICKS_W       = 16;
    localparam int CFG_ADDR_W          = 4;
    localparam int CFG_DATA_W          = 32;
    localparam int IN_DATA_W           = 16;
    localparam int IN_USER_W           = 2;
    localparam int OUT_DATA_W          = 16;

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_INSTR  = 2'd1,
        CMD_CHAR   = 2'd2,
        CMD_CURSOR = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        REG_FOUR_BIT     = 2'd0,
        REG_PHASE_TICKS  = 2'd1,
        REG_DISPLAY_TYPE = 2'd2,
        REG_NONE         = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_HI1  = 3'd1,
        PH_LO1  = 3'd2,
        PH_HI2  = 3'd3,
        PH_LO2  = 3'd4
    } phase_t;

    typedef struct packed {
        logic                     four_bit_mode;
        logic [PHASE_TICKS_W-1:0] phase_ticks;
        logic                     display_type;
    } cfg_t;

    typedef struct packed {
        logic       rejected;
        logic       busy_res;
        logic [7:0] data_lines;
        logic       enable_line;
        logic       rw_line;
        logic       rs_line;
    } res_t;

    localparam logic [7:0] ROW0_BASE = 8'h80;
    localparam logic [7:0] ROW1_BASE = 8'hC0;
    localparam logic [7:0] ROW2_BASE = 8'h94;
    localparam logic [7:0] ROW3_BASE = 8'hD4;

    function automatic logic [7:0] row_base(input logic [1:0] row);
        logic [7:0] base;
        unique case (row)
            2'd0:    base = ROW0_BASE;
            2'd1:    base = ROW1_BASE;
            2'd2:    base = ROW2_BASE;
            default: base = ROW3_BASE;
        endcase
        return base;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/clcd_seq_core.sv
// ----------------------------------------------------------------------------
// clcd_seq_core
// bus phase state, tick counting and line levels of the lcd write sequencer
// ----------------------------------------------------------------------------
`default_nettype none

module clcd_seq_core #(
    parameter int TICK_COUNT_BITS = clcd_pkg::TICK_COUNT_BITS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          step,
    input  wire logic [1:0]    command,
    input  wire logic [7:0]    byte_value,
    input  wire logic [1:0]    row,
    input  wire logic [5:0]    column,
    input  wire clcd_pkg::cfg_t cfg,
    output clcd_pkg::res_t     res
);

    localparam logic [31:0] CNT_MAX = 32'((64'(1) << TICK_COUNT_BITS) - 64'(1));

    clcd_pkg::phase_t            phase_reg, phase_next;
    logic [TICK_COUNT_BITS-1:0]  tick_reg, tick_next, tick_dec, tick_len;
    logic [7:0]                  held_byte_reg, held_byte_next;
    logic                        held_sel_reg, held_sel_next;
    logic [7:0]                  data_reg, data_next;
    logic                        en_reg, en_next;
    logic                        rej;
    logic                        start;
    logic                        start_sel;
    logic [7:0]                  start_byte;
    logic [31:0]                 len_wide;
    clcd_pkg::cmd_t              cmd;

    assign cmd = clcd_pkg::cmd_t'(command);

    always_comb
    begin
        len_wide = 32'(cfg.phase_ticks);
        if (len_wide == 32'd0)
        begin
            len_wide = 32'd1;
        end
        if (len_wide > CNT_MAX)
        begin
            len_wide = CNT_MAX;
        end
        tick_len = len_wide[TICK_COUNT_BITS-1:0];
    end

    assign tick_dec = (tick_reg != '0) ? tick_reg - TICK_COUNT_BITS'(1) : tick_reg;

    always_comb
    begin
        phase_next     = phase_reg;
        tick_next      = tick_reg;
        held_byte_next = held_byte_reg;
        held_sel_next  = held_sel_reg;
        data_next      = data_reg;
        en_next        = en_reg;
        rej            = 1'b0;
        start          = 1'b0;
        start_sel      = 1'b0;
        start_byte     = byte_value;

        unique case (cmd)
            clcd_pkg::CMD_TICK:
            begin
                if (phase_reg != clcd_pkg::PH_IDLE)
                begin
                    tick_next = tick_dec;
                    if (tick_dec == '0)
                    begin
                        unique case (phase_reg)
                            clcd_pkg::PH_HI1:
                            begin
                                en_next    = 1'b0;
                                phase_next = clcd_pkg::PH_LO1;
                                tick_next  = tick_len;
                            end
                            clcd_pkg::PH_LO1:
                            begin
                                if (cfg.four_bit_mode)
                                begin
                                    data_next  = {held_byte_reg[3:0], 4'b0000};
                                    en_next    = 1'b1;
                                    phase_next = clcd_pkg::PH_HI2;
                                    tick_next  = tick_len;
                                end
                                else
                                begin
                                    phase_next = clcd_pkg::PH_IDLE;
                                end
                            end
                            clcd_pkg::PH_HI2:
                            begin
                                en_next    = 1'b0;
                                phase_next = clcd_pkg::PH_LO2;
                                tick_next  = tick_len;
                            end
                            default:
                            begin
                                phase_next = clcd_pkg::PH_IDLE;
                            end
                        endcase
                    end
                end
            end
            clcd_pkg::CMD_INSTR:
            begin
                start = 1'b1;
            end
            clcd_pkg::CMD_CHAR:
            begin
                start     = 1'b1;
                start_sel = 1'b1;
            end
            default:
            begin
                start_byte = clcd_pkg::row_base(row) + {2'b00, column};
                if (!cfg.display_type && row[1])
                begin
                    rej = 1'b1;
                end
                else
                begin
                    start = 1'b1;
                end
            end
        endcase

        if (start)
        begin
            if (phase_reg != clcd_pkg::PH_IDLE)
            begin
                rej = 1'b1;
            end
            else
            begin
                held_byte_next = start_byte;
                held_sel_next  = start_sel;
                data_next      = cfg.four_bit_mode ? {start_byte[7:4], 4'b0000} : start_byte;
                en_next        = 1'b1;
                phase_next     = clcd_pkg::PH_HI1;
                tick_next      = tick_len;
            end
        end
        else if (rej && phase_reg != clcd_pkg::PH_IDLE)
        begin
            rej = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= clcd_pkg::PH_IDLE;
            tick_reg      <= '0;
            held_byte_reg <= '0;
            held_sel_reg  <= 1'b0;
            data_reg      <= '0;
            en_reg        <= 1'b0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            tick_reg      <= tick_next;
            held_byte_reg <= held_byte_next;
            held_sel_reg  <= held_sel_next;
            data_reg      <= data_next;
            en_reg        <= en_next;
        end
    end

    always_comb
    begin
        res.rs_line     = held_sel_next;
        res.rw_line     = 1'b0;
        res.enable_line = en_next;
        res.data_lines  = data_next;
        res.busy_res    = (phase_next != clcd_pkg::PH_IDLE);
        res.rejected    = rej;
    end

endmodule

`default_nettype wire

FILE: hdl/char_lcd_write_sequencer_top.sv
// ----------------------------------------------------------------------------
// char_lcd_write_sequencer_top
// character lcd parallel write sequencer with stream ports and apb registers
// ----------------------------------------------------------------------------
// input words on s_*: tuser carries the command (tick, instruction byte,
// character byte, set cursor), tdata the byte, row and column. every
// accepted word yields exactly one output word on m_* with the rs, rw,
// enable and data line levels after that step, plus busy and rejected.
// m_tvalid is registered and rises in the cycle after accept; throughput is
// one word per cycle while the receiver does not stall, set by the single
// state update in the core feeding the output register. s_tready is high
// whenever the output register is empty or is being taken in the same
// cycle, so a stalled receiver stalls the input after one word and nothing
// is dropped. reset clears the phase state, tick counter and lines to low,
// the output register to empty, and the registers to 8-bit mode, one tick
// per phase and a 16x2 display. registers (apb, byte address 4*i):
// four_bit_mode, phase_ticks, display_type; write them only while no word is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module char_lcd_write_sequencer_top #(
    parameter int TICK_COUNT_BITS = clcd_pkg::TICK_COUNT_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // byte_value[7:0], row[9:8], column[15:10]
    input  wire logic [clcd_pkg::IN_DATA_W-1:0]    s_tdata,
    // command[1:0]
    input  wire logic [clcd_pkg::IN_USER_W-1:0]    s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // rs_line[0], rw_line[1], enable_line[2], data_lines[10:3], busy_res[11],
    // rejected[12], zero[15:13]
    output logic [clcd_pkg::OUT_DATA_W-1:0]        m_tdata,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [clcd_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire logic [clcd_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [clcd_pkg::CFG_DATA_W-1:0]        prdata,
    output logic                                   pready
);

    clcd_pkg::cfg_t                      cfg_reg, cfg_next;
    clcd_pkg::res_t                      res;
    clcd_pkg::reg_idx_t                  reg_idx;
    logic                                cfg_wr;
    logic                                accept;
    logic                                m_tvalid_reg, m_tvalid_next;
    logic [clcd_pkg::OUT_DATA_W-1:0]     m_tdata_reg, m_tdata_next;

    assign pready  = 1'b1;
    assign reg_idx = clcd_pkg::reg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            unique case (reg_idx)
                clcd_pkg::REG_FOUR_BIT:     cfg_next.four_bit_mode = pwdata[0];
                clcd_pkg::REG_PHASE_TICKS:  cfg_next.phase_ticks   =
                                                pwdata[clcd_pkg::PHASE_TICKS_W-1:0];
                clcd_pkg::REG_DISPLAY_TYPE: cfg_next.display_type  = pwdata[0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            clcd_pkg::REG_FOUR_BIT:     prdata = 32'(cfg_reg.four_bit_mode);
            clcd_pkg::REG_PHASE_TICKS:  prdata = 32'(cfg_reg.phase_ticks);
            clcd_pkg::REG_DISPLAY_TYPE: prdata = 32'(cfg_reg.display_type);
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.four_bit_mode <= 1'b0;
            cfg_reg.phase_ticks   <= clcd_pkg::PHASE_TICKS_W'(1);
            cfg_reg.display_type  <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    clcd_seq_core #(
        .TICK_COUNT_BITS (TICK_COUNT_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (accept),
        .command    (s_tuser),
        .byte_value (s_tdata[7:0]),
        .row        (s_tdata[9:8]),
        .column     (s_tdata[15:10]),
        .cfg        (cfg_reg),
        .res        (res)
    );

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (accept)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {3'b000, res};
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

FILE: hdl/clcd_checker.sv
// ----------------------------------------------------------------------------
// clcd_checker
// port-level checks of the lcd write sequencer, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "char_lcd_write_sequencer_top_assert.svh"

module clcd_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              s_tvalid,
    input wire logic                              s_tready,
    input wire logic [clcd_pkg::IN_USER_W-1:0]    s_tuser,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [clcd_pkg::OUT_DATA_W-1:0]   m_tdata
);

    logic in_acc;
    logic tick_acc;
    logic out_busy;
    logic out_en;
    logic out_rej;
    logic out_stall;

    assign in_acc    = s_tvalid && s_tready;
    assign tick_acc  = in_acc && (s_tuser == clcd_pkg::CMD_TICK);
    assign out_en    = m_tdata[2];
    assign out_busy  = m_tdata[11];
    assign out_rej   = m_tdata[12];
    assign out_stall = m_tvalid && !m_tready;

    // every accepted word shows up on the output next cycle
    `CLCD_ASSERT_NEXT(a_result_follows, in_acc, m_tvalid, "accepted word gave no result")

    // a tick is never rejected
    `CLCD_ASSERT_NEXT(a_tick_not_rejected, tick_acc, !out_rej, "tick word flagged rejected")

    // enable only pulses inside a transfer
    `CLCD_ASSERT_NOW(a_idle_enable_low, m_tvalid && !out_busy, !out_en, "enable high while idle")

    // stalled result holds
    `CLCD_ASSERT_NEXT(a_stall_hold, out_stall, m_tvalid && $stable(m_tdata), "stall moved result")

endmodule

bind char_lcd_write_sequencer_top clcd_checker u_clcd_checker (.*);

`default_nettype wire
